// ===== sv/wrrmq_pkg.sv =====
// ----------------------------------------------------------------------------
// wrrmq_pkg
// Shared constants, types and helper functions of the weighted round robin
// multi-queue core.
// ----------------------------------------------------------------------------
package wrrmq_pkg;

   // queue geometry
   localparam int NUM_QUEUES  = 4;
   localparam int QUEUE_DEPTH = 16;

   // configuration registers
   localparam int NUM_WEIGHTS = 4;
   localparam int WEIGHT_W    = 8;
   localparam int CSR_IDX_W   = 3;

   // payload widths
   localparam int DATA_W = 32;
   localparam int QIDX_W = 3;

   // derived widths
   localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW        = $clog2(QUEUE_DEPTH);
   localparam int CW        = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int AW        = $clog2(MEM_DEPTH);

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_BAD_INDEX = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // per-item result control handed from the scheduler to the output stage
   typedef struct packed {
      status_type status;
      logic       pop_ok;
      logic       peek_valid;
      logic       peek_fwd;
   } resp_info_type;

   // queue memory access for one item
   typedef struct packed {
      logic              we;
      logic [AW-1:0]     waddr;
      logic [DATA_W-1:0] wdata;
      logic [AW-1:0]     raddr_pop;
      logic [AW-1:0]     raddr_peek;
   } mem_access_type;

   // ring pointer advance with wrap at the queue depth
   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   // round robin advance with wrap at the queue count
   function automatic logic [QW-1:0] next_queue(input logic [QW-1:0] q);
      logic [QW-1:0] r;
      if (q == QW'(NUM_QUEUES - 1)) begin
         r = '0;
      end else begin
         r = q + QW'(1);
      end
      return r;
   endfunction

   // flat memory address of a queue slot
   function automatic logic [AW-1:0] mem_addr(input logic [QW-1:0] q,
                                              input logic [PW-1:0] p);
      return AW'(int'(q) * QUEUE_DEPTH + int'(p));
   endfunction

endpackage

// ===== sv/wrrmq_ram.sv =====
// ----------------------------------------------------------------------------
// wrrmq_ram
// Single-write, dual-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module wrrmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr_a,
   input  logic [ADDR_W-1:0] raddr_b,
   output logic [WIDTH-1:0]  rdata_a,
   output logic [WIDTH-1:0]  rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read ports, old data on a same-address write
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a <= mem[raddr_a];
         rdata_b <= mem[raddr_b];
      end
   end

endmodule

// ===== sv/wrrmq_sched.sv =====
// ----------------------------------------------------------------------------
// wrrmq_sched
// Queue pointers, occupancy and round robin turn state; decides each item's
// memory accesses and result status.
// ----------------------------------------------------------------------------
module wrrmq_sched
   import wrrmq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                command,
   input  logic [QIDX_W-1:0]   queue_index,
   input  logic [DATA_W-1:0]   push_value,
   input  logic [WEIGHT_W-1:0] weight [NUM_QUEUES],
   output mem_access_type      mem_acc,
   output resp_info_type       info
);

   logic [PW-1:0]       head_ff  [NUM_QUEUES];
   logic [PW-1:0]       head_in  [NUM_QUEUES];
   logic [PW-1:0]       tail_ff  [NUM_QUEUES];
   logic [PW-1:0]       tail_in  [NUM_QUEUES];
   logic [CW-1:0]       count_ff [NUM_QUEUES];
   logic [CW-1:0]       count_in [NUM_QUEUES];
   logic [QW-1:0]       cur_ff;
   logic [QW-1:0]       cur_in;
   logic [WEIGHT_W-1:0] served_ff;
   logic [WEIGHT_W-1:0] served_in;

   logic          push_ok;
   logic          push_bad;
   logic          push_full;
   logic [QW-1:0] push_q;
   logic          pop_ok;
   logic [QW-1:0] pop_q;
   logic          peek_valid;
   logic [QW-1:0] peek_q;

   // push target checks
   always_comb begin
      push_bad  = int'(queue_index) >= NUM_QUEUES;
      push_q    = queue_index[QW-1:0];
      push_full = count_ff[push_q] == CW'(QUEUE_DEPTH);
      push_ok   = (command == CMD_PUSH) && !push_bad && !push_full;
   end

   // weighted round robin search, at most one visit per queue
   always_comb begin
      logic [QW-1:0]       q_v;
      logic [WEIGHT_W-1:0] sc_v;
      logic [WEIGHT_W-1:0] sc_next;
      logic                found;
      q_v       = cur_ff;
      sc_v      = served_ff;
      sc_next   = '0;
      found     = 1'b0;
      pop_q     = cur_ff;
      cur_in    = cur_ff;
      served_in = served_ff;
      for (int k = 0; k < NUM_QUEUES; k++) begin
         if (!found) begin
            if (count_ff[q_v] != '0 && sc_v < weight[q_v]) begin
               found   = 1'b1;
               pop_q   = q_v;
               sc_next = sc_v + WEIGHT_W'(1);
               if (sc_next == weight[q_v]) begin
                  cur_in    = next_queue(q_v);
                  served_in = '0;
               end else begin
                  cur_in    = q_v;
                  served_in = sc_next;
               end
            end else begin
               q_v  = next_queue(q_v);
               sc_v = '0;
            end
         end
      end
      if (!found) begin
         cur_in    = q_v;
         served_in = '0;
      end
      pop_ok = (command == CMD_POP) && found;
   end

   // pointer and occupancy updates
   always_comb begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         head_in[i]  = head_ff[i];
         tail_in[i]  = tail_ff[i];
         count_in[i] = count_ff[i];
         if (push_ok && push_q == QW'(i)) begin
            tail_in[i]  = next_ptr(tail_ff[i]);
            count_in[i] = count_ff[i] + CW'(1);
         end
         if (pop_ok && pop_q == QW'(i)) begin
            head_in[i]  = next_ptr(head_ff[i]);
            count_in[i] = count_ff[i] - CW'(1);
         end
      end
   end

   // lowest-numbered non-empty queue after this item
   always_comb begin
      peek_valid = 1'b0;
      peek_q     = '0;
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         if (count_in[i] != '0) begin
            peek_valid = 1'b1;
            peek_q     = QW'(i);
         end
      end
   end

   // memory accesses and result control
   always_comb begin
      mem_acc.we         = accept && push_ok;
      mem_acc.waddr      = mem_addr(push_q, tail_ff[push_q]);
      mem_acc.wdata      = push_value;
      mem_acc.raddr_pop  = mem_addr(pop_q, head_ff[pop_q]);
      mem_acc.raddr_peek = mem_addr(peek_q, head_in[peek_q]);

      if (command == CMD_POP) begin
         info.status = pop_ok ? STATUS_OK : STATUS_EMPTY;
      end else if (push_bad) begin
         info.status = STATUS_BAD_INDEX;
      end else if (push_full) begin
         info.status = STATUS_FULL;
      end else begin
         info.status = STATUS_OK;
      end
      info.pop_ok     = pop_ok;
      info.peek_valid = peek_valid;
      // a push into an empty front queue is read back before it lands
      info.peek_fwd   = push_ok && (mem_acc.raddr_peek == mem_acc.waddr);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         cur_ff    <= '0;
         served_ff <= '0;
      end else if (accept) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= head_in[i];
            tail_ff[i]  <= tail_in[i];
            count_ff[i] <= count_in[i];
         end
         if (command == CMD_POP) begin
            cur_ff    <= cur_in;
            served_ff <= served_in;
         end
      end
   end

endmodule

// ===== sv/weighted_round_robin_multi_queue_core.sv =====
// ----------------------------------------------------------------------------
// weighted_round_robin_multi_queue_core
// Several FIFO queues of signed words in one shared memory, served by
// weighted round robin, with per-item status and a front-word peek.
// ----------------------------------------------------------------------------
// Each item is handled in order: the cycle it is accepted updates pointers and
// issues both queue memory reads (popped word and new front word), and once the
// result register is free it is loaded from the registered read data. A new item
// is not accepted while an earlier one still waits to load the result register.
// The queue memory needs no clearing after reset; weights reset to one.
module weighted_round_robin_multi_queue_core
   import wrrmq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [WEIGHT_W-1:0]      csr_write_data,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic [QIDX_W-1:0]        req_queue_index,
   input  logic signed [DATA_W-1:0] req_push_value,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_pop_value,
   output logic                     rsp_all_empty,
   output logic                     rsp_peek_valid,
   output logic signed [DATA_W-1:0] rsp_peek_value
);

   logic [WEIGHT_W-1:0] weight_ff [NUM_WEIGHTS];
   logic [WEIGHT_W-1:0] weight_use [NUM_QUEUES];

   logic              accept;
   logic              out_free;
   mem_access_type    mem_acc;
   resp_info_type     info;
   resp_info_type     info_ff;
   logic              pend_ff;
   logic [DATA_W-1:0] fwd_data_ff;
   logic [DATA_W-1:0] rd_pop;
   logic [DATA_W-1:0] rd_peek;
   logic [DATA_W-1:0] peek_word;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [DATA_W-1:0] rsp_pop_value_ff;
   logic              rsp_all_empty_ff;
   logic              rsp_peek_valid_ff;
   logic [DATA_W-1:0] rsp_peek_value_ff;

   // weight registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WEIGHTS; i++) begin
            weight_ff[i] <= WEIGHT_W'(1);
         end
      end else if (csr_write_enable) begin
         for (int i = 0; i < NUM_WEIGHTS; i++) begin
            if (csr_index == CSR_IDX_W'(i)) begin
               weight_ff[i] <= csr_write_data;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         weight_use[i] = weight_ff[i];
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   wrrmq_sched u_sched (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_command),
      .queue_index (req_queue_index),
      .push_value  (req_push_value),
      .weight      (weight_use),
      .mem_acc     (mem_acc),
      .info        (info)
   );

   wrrmq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .we      (mem_acc.we),
      .waddr   (mem_acc.waddr),
      .wdata   (mem_acc.wdata),
      .re      (accept),
      .raddr_a (mem_acc.raddr_pop),
      .raddr_b (mem_acc.raddr_peek),
      .rdata_a (rd_pop),
      .rdata_b (rd_peek)
   );

   // read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (accept) begin
         pend_ff <= 1'b1;
      end else if (pend_ff && out_free) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff     <= info;
         fwd_data_ff <= mem_acc.wdata;
      end
   end

   assign peek_word = info_ff.peek_fwd ? fwd_data_ff : rd_peek;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_ff && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff && out_free) begin
         rsp_status_ff     <= info_ff.status;
         rsp_pop_value_ff  <= info_ff.pop_ok ? rd_pop : '0;
         rsp_all_empty_ff  <= !info_ff.peek_valid;
         rsp_peek_valid_ff <= info_ff.peek_valid;
         rsp_peek_value_ff <= info_ff.peek_valid ? peek_word : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pop_value  = rsp_pop_value_ff;
   assign rsp_all_empty  = rsp_all_empty_ff;
   assign rsp_peek_valid = rsp_peek_valid_ff;
   assign rsp_peek_value = rsp_peek_value_ff;

endmodule
